// ----- rtl/core/rgbds_pkg.sv -----
package rgbds_pkg;

  localparam int unsigned PixW     = 16;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PhaseW-1:0] PhaseA    = 3'd0;
  localparam logic [PhaseW-1:0] PhaseB    = 3'd1;
  localparam logic [PhaseW-1:0] PhaseC    = 3'd2;
  localparam logic [PhaseW-1:0] PhaseD    = 3'd3;
  localparam logic [PhaseW-1:0] PhaseE    = 3'd4;
  localparam logic [PhaseW-1:0] PhaseF    = 3'd5;

  localparam logic RegSmoothMode = 1'b0;

  typedef struct packed {
    logic [PixW-1:0]   px;
    logic [PixW-1:0]   held;
    logic [PhaseW-1:0] phase;
    logic              smooth;
  } stage_t;

  // truncating divide by five via reciprocal, exact for 0..315
  function automatic logic [5:0] div5(input logic [8:0] x);
    logic [16:0] prod;
    prod = 17'(x) * 17'd205;
    return prod[15:10];
  endfunction

endpackage

// ----- rtl/core/rgbds_cfg.sv -----
module rgbds_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbds_pkg::CfgAddrW-1:0]    paddr,
  input  logic [rgbds_pkg::CfgDataW-1:0]    pwdata,
  output logic [rgbds_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready,
  output logic                              smooth_mode_o
);

  logic smooth_q, smooth_d;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && (reg_idx == rgbds_pkg::RegSmoothMode);

  always_comb begin
    smooth_d = smooth_q;
    if (wr_en) begin
      smooth_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 1'b1;
    end else begin
      smooth_q <= smooth_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == rgbds_pkg::RegSmoothMode) begin
      prdata = {{(rgbds_pkg::CfgDataW-1){1'b0}}, smooth_q};
    end
  end

  assign smooth_mode_o = smooth_q;

endmodule

// ----- rtl/core/rgbds_blend.sv -----
module rgbds_blend (
  input  rgbds_pkg::stage_t              stage_i,
  output logic [rgbds_pkg::PixW-1:0]     pixel_o,
  output logic                           emit_o
);

  logic [4:0] hr, hb, pr, pb;
  logic [5:0] hg, pg;
  logic [2:0] wp, wq;
  logic [8:0] sum_r, sum_g, sum_b;
  logic [4:0] mix_r, mix_b;
  logic [5:0] mix_g;
  logic [5:0] avg_r, avg_b;
  logic [6:0] avg_g;
  logic [rgbds_pkg::PixW-1:0] mix5, avg2;

  assign hr = stage_i.held[15:11];
  assign hg = stage_i.held[10:5];
  assign hb = stage_i.held[4:0];
  assign pr = stage_i.px[15:11];
  assign pg = stage_i.px[10:5];
  assign pb = stage_i.px[4:0];

  always_comb begin
    case (stage_i.phase)
      rgbds_pkg::PhaseC: begin wp = 3'd4; wq = 3'd1; end
      rgbds_pkg::PhaseD: begin wp = 3'd3; wq = 3'd2; end
      rgbds_pkg::PhaseE: begin wp = 3'd2; wq = 3'd3; end
      default:           begin wp = 3'd1; wq = 3'd4; end
    endcase
  end

  assign sum_r = 9'(hr) * 9'(wp) + 9'(pr) * 9'(wq);
  assign sum_g = 9'(hg) * 9'(wp) + 9'(pg) * 9'(wq);
  assign sum_b = 9'(hb) * 9'(wp) + 9'(pb) * 9'(wq);

  assign mix_r = 5'(rgbds_pkg::div5(sum_r));
  assign mix_g = rgbds_pkg::div5(sum_g);
  assign mix_b = 5'(rgbds_pkg::div5(sum_b));
  assign mix5  = {mix_r, mix_g, mix_b};

  assign avg_r = 6'(hr) + 6'(pr);
  assign avg_g = 7'(hg) + 7'(pg);
  assign avg_b = 6'(hb) + 6'(pb);
  assign avg2  = {avg_r[5:1], avg_g[6:1], avg_b[5:1]};

  always_comb begin
    pixel_o = stage_i.px;
    emit_o  = 1'b1;
    if (stage_i.smooth) begin
      case (stage_i.phase)
        rgbds_pkg::PhaseA: pixel_o = stage_i.px;
        rgbds_pkg::PhaseB: emit_o  = 1'b0;
        default:           pixel_o = mix5;
      endcase
    end else begin
      case (stage_i.phase)
        rgbds_pkg::PhaseE: emit_o  = 1'b0;
        rgbds_pkg::PhaseF: pixel_o = avg2;
        default:           pixel_o = stage_i.px;
      endcase
    end
  end

endmodule

// ----- rtl/core/rgb565_six_to_five_downscaler.sv -----
// rgb565 horizontal six-to-five downscaler
//
// s_axis carries source pixels (tdata = rgb565), m_axis carries the
// downscaled pixels; every group of six input beats yields five output beats.
// smooth_mode (apb, address 0, bit 0) picks weighted fifth blending (1) or
// copy plus last-pair average (0); write it only while the stream is idle.
//
// one beat per clock is accepted in steady state while m_axis_tready stays
// high. a pixel is registered at the input stage, blended by a small
// combinational stage (shift-add and a reciprocal multiply per channel) and
// lands in the output register. the beat that produces no pixel is dropped
// between the two stages.
//
// reset clears the phase counter and held pixel and sets smooth mode.
// when m_axis_tready is low the output register holds; the input stage
// still takes a beat if it is empty, then s_axis_tready falls until the output drains.
module rgb565_six_to_five_downscaler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rgbds_pkg::PixW-1:0]     s_axis_tdata,  // in_pixel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [rgbds_pkg::PixW-1:0]     m_axis_tdata,  // out_pixel
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rgbds_pkg::CfgAddrW-1:0] paddr,
  input  logic [rgbds_pkg::CfgDataW-1:0] pwdata,
  output logic [rgbds_pkg::CfgDataW-1:0] prdata,
  output logic                           pready
);

  logic                          smooth_mode;
  logic [rgbds_pkg::PhaseW-1:0]  phase_q, phase_d, phase_n;
  logic [rgbds_pkg::PixW-1:0]    held_q, held_d;
  rgbds_pkg::stage_t             s1_q, s1_d;
  logic                          s1_v_q, s1_v_d;
  logic [rgbds_pkg::PixW-1:0]    s2_q, s2_d;
  logic                          s2_v_q, s2_v_d;
  logic [rgbds_pkg::PixW-1:0]    blend_px;
  logic                          blend_emit;
  logic                          s_acc, s2_ready;

  rgbds_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .smooth_mode_o (smooth_mode)
  );

  rgbds_blend u_blend (
    .stage_i (s1_q),
    .pixel_o (blend_px),
    .emit_o  (blend_emit)
  );

  assign s2_ready      = !s2_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || s2_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign phase_n = (phase_q > rgbds_pkg::PhaseF) ? rgbds_pkg::PhaseA : phase_q;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    s1_d    = s1_q;
    s1_v_d  = s1_v_q;
    s2_d    = s2_q;
    s2_v_d  = s2_v_q;
    if (s_axis_tready) begin
      s1_v_d = s_acc;
    end
    if (s_acc) begin
      phase_d = (phase_n == rgbds_pkg::PhaseF) ? rgbds_pkg::PhaseA : phase_n + 3'd1;
      held_d  = s_axis_tdata;
      s1_d.px     = s_axis_tdata;
      s1_d.held   = held_q;
      s1_d.phase  = phase_n;
      s1_d.smooth = smooth_mode;
    end
    if (s2_ready) begin
      s2_v_d = s1_v_q && blend_emit;
      s2_d   = blend_px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rgbds_pkg::PhaseA;
      held_q  <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      s1_v_q  <= s1_v_d;
      s2_v_q  <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
  end

  assign m_axis_tvalid = s2_v_q;
  assign m_axis_tdata  = s2_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= rgbds_pkg::PhaseF)
    else $error("phase counter out of range");

  a_phase_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc && (phase_q == rgbds_pkg::PhaseF) |=> phase_q == rgbds_pkg::PhaseA)
    else $error("phase did not wrap after sixth beat");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> s1_v_q && s2_v_q && !m_axis_tready)
    else $error("input stalled without a full pipeline");

  a_held_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> held_q == $past(s_axis_tdata))
    else $error("held pixel not updated on input beat");

endmodule

// ----- dv/rgb565_six_to_five_downscaler_test.sv -----
`timescale 1ns / 1ps

module rgb565_six_to_five_downscaler_test;

  localparam logic [rgbds_pkg::CfgAddrW-1:0] SmoothModeAddr = {rgbds_pkg::RegSmoothMode, 2'b00};
  localparam logic [rgbds_pkg::CfgDataW-1:0] ModeFast       = 32'd0;
  localparam logic [rgbds_pkg::CfgDataW-1:0] ModeSmooth     = 32'd1;
  localparam int unsigned                    StallLimit     = 4000;
  localparam int unsigned                    SettleCycles   = 4;
  localparam int unsigned                    DrainCycles    = 8;

  class downscale_scoreboard;
    logic                         smooth;
    logic [rgbds_pkg::PhaseW-1:0] phase;
    logic [rgbds_pkg::PixW-1:0]   held;
    logic [rgbds_pkg::PixW-1:0]   expected_px[$];
    int unsigned                  mismatches;
    int unsigned                  pixels_in;
    int unsigned                  pixels_out;

    function new();
      smooth     = 1'b1;
      phase      = rgbds_pkg::PhaseA;
      held       = '0;
      mismatches = 0;
      pixels_in  = 0;
      pixels_out = 0;
    endfunction

    // per-channel weighted average with truncation
    function automatic logic [rgbds_pkg::PixW-1:0] blend(logic [rgbds_pkg::PixW-1:0] p,
                                                         logic [rgbds_pkg::PixW-1:0] q,
                                                         int unsigned wp, int unsigned wq,
                                                         int unsigned dv);
      int unsigned r, g, b;
      r = (p[15:11] * wp + q[15:11] * wq) / dv;
      g = (p[10:5] * wp + q[10:5] * wq) / dv;
      b = (p[4:0] * wp + q[4:0] * wq) / dv;
      return {r[4:0], g[5:0], b[4:0]};
    endfunction

    function void note_pixel(logic [rgbds_pkg::PixW-1:0] px);
      logic [rgbds_pkg::PhaseW-1:0] ph;
      logic [rgbds_pkg::PixW-1:0]   res;
      logic                         emit;
      ph   = (phase > rgbds_pkg::PhaseF) ? rgbds_pkg::PhaseA : phase;
      emit = 1'b1;
      res  = px;
      if (smooth) begin
        case (ph)
          rgbds_pkg::PhaseA: res = px;
          rgbds_pkg::PhaseB: emit = 1'b0;
          rgbds_pkg::PhaseC: res = blend(held, px, 4, 1, 5);
          rgbds_pkg::PhaseD: res = blend(held, px, 3, 2, 5);
          rgbds_pkg::PhaseE: res = blend(held, px, 2, 3, 5);
          default: res = blend(held, px, 1, 4, 5);
        endcase
      end else begin
        if (ph == rgbds_pkg::PhaseE) emit = 1'b0;
        else if (ph == rgbds_pkg::PhaseF) res = blend(held, px, 1, 1, 2);
      end
      held  = px;
      phase = (ph == rgbds_pkg::PhaseF) ? rgbds_pkg::PhaseA : ph + 1'b1;
      pixels_in++;
      if (emit) expected_px.push_back(res);
    endfunction

    function void check_pixel(logic [rgbds_pkg::PixW-1:0] px);
      logic [rgbds_pkg::PixW-1:0] want;
      pixels_out++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output pixel %h", px);
        return;
      end
      want = expected_px.pop_front();
      if (px !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output pixel %0d: expected %h, got %h", pixels_out, want, px);
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [rgbds_pkg::PixW-1:0]     s_axis_tdata  = '0;  // in_pixel
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [rgbds_pkg::PixW-1:0]     m_axis_tdata;        // out_pixel
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [rgbds_pkg::CfgAddrW-1:0] paddr         = '0;
  logic [rgbds_pkg::CfgDataW-1:0] pwdata        = '0;
  logic [rgbds_pkg::CfgDataW-1:0] prdata;
  logic                           pready;

  downscale_scoreboard sb = new();
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned fast_writes    = 0;
  int unsigned smooth_writes  = 0;

  rgb565_six_to_five_downscaler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_pixel(s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_pixel(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("timeout: no beat for %0d cycles", StallLimit);
      $display("rgb565_six_to_five_downscaler_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [rgbds_pkg::PixW-1:0] px);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // stop the source and let the pipeline empty before touching the mode
  task automatic drain_stream();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic [rgbds_pkg::CfgDataW-1:0] mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SmoothModeAddr;
    pwdata  <= mode;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.smooth = mode[0];
    if (mode[0]) smooth_writes++;
    else fast_writes++;
  endtask

  function automatic logic [rgbds_pkg::PixW-1:0] rand_pixel();
    logic [31:0] rnd;
    logic [4:0]  r;
    logic [5:0]  g;
    logic [4:0]  b;
    rnd = $urandom;
    if ($urandom_range(0, 2) != 0) return rnd[15:0];
    r = ($urandom_range(0, 2) == 0) ? 5'h00 : ($urandom_range(0, 1) ? 5'h1f : 5'($urandom));
    g = ($urandom_range(0, 2) == 0) ? 6'h00 : ($urandom_range(0, 1) ? 6'h3f : 6'($urandom));
    b = ($urandom_range(0, 2) == 0) ? 5'h00 : ($urandom_range(0, 1) ? 5'h1f : 5'($urandom));
    return {r, g, b};
  endfunction

  initial begin
    logic [rgbds_pkg::PixW-1:0] smooth_px[12];
    logic [rgbds_pkg::PixW-1:0] fast_px[9];
    int unsigned                idle_cfg[4][2];
    smooth_px = '{16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff,
                  16'hf800, 16'h07e0, 16'h001f, 16'hf800, 16'h07e0, 16'h001f};
    fast_px   = '{16'h0000, 16'hffff, 16'hf800, 16'h07e0, 16'hffff, 16'hffff,
                  16'h0001, 16'h8000, 16'hfffe};
    idle_cfg  = '{'{0, 0}, '{74, 0}, '{0, 74}, '{27, 27}};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes in both modes, last group left open across a mode change
    write_mode(ModeSmooth);
    foreach (smooth_px[i]) send_pixel(smooth_px[i]);
    drain_stream();
    write_mode(ModeFast);
    foreach (fast_px[i]) send_pixel(fast_px[i]);
    drain_stream();
    write_mode(ModeSmooth);

    for (int p = 0; p < 4; p++) begin
      src_idle_pct   = idle_cfg[p][0];
      sink_stall_pct = idle_cfg[p][1];
      for (int s = 0; s < 2; s++) begin
        if (((p + s) % 2) == 0) write_mode(ModeSmooth);
        else write_mode(ModeFast);
        repeat ($urandom_range(55, 85)) send_pixel(rand_pixel());
        drain_stream();
      end
    end

    sink_stall_pct = 0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d pixels sent, %0d downscaled pixels checked, %0d mismatches",
             sb.pixels_in, sb.pixels_out, sb.mismatches);
    $display("mode writes: %0d smooth, %0d fast, under four idle and stall mixes",
             smooth_writes, fast_writes);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("rgb565_six_to_five_downscaler_test: PASS");
    end else begin
      $display("rgb565_six_to_five_downscaler_test: FAIL");
    end
    $finish;
  end

endmodule

// ----- rgb565_six_to_five_downscaler.f -----
rtl/core/rgbds_pkg.sv
rtl/core/rgbds_cfg.sv
rtl/core/rgbds_blend.sv
rtl/core/rgb565_six_to_five_downscaler.sv
dv/rgb565_six_to_five_downscaler_test.sv
